>>> hw/rtl/ckpq_pkg.sv
// ----------------------------------------------------------------------------
// ckpq_pkg
// Shared types, constants and the ordering function for the priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ckpq_pkg;

  // Store depth and the width of the fill counter that goes with it.
  localparam int NUM_CELLS = 64;
  localparam int CNT_W     = $clog2(NUM_CELLS + 1);

  // Date value: year*10000 + month*100 + day, at most 163842827.
  localparam int DATE_W    = 28;
  localparam int YEAR_MUL  = 10000;
  localparam int MONTH_MUL = 100;
  localparam int ARR_W     = 32;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_COUNT  = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2
  } status_e;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Request transaction payload.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  category_code;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [15:0] subject_tag;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_count;
    logic [2:0]  top_category;
    logic [13:0] top_year;
    logic [6:0]  top_month;
    logic [6:0]  top_day;
    logic [15:0] top_tag;
  } out_t;

  // One stored entry, with its date value kept alongside the raw fields.
  typedef struct packed {
    logic [2:0]        cat;
    logic [13:0]       year;
    logic [6:0]        month;
    logic [6:0]        day;
    logic [DATE_W-1:0] date;
    logic [ARR_W-1:0]  arrival;
    logic [15:0]       tag;
  } entry_t;

  // Operation applied to every cell of the chain in the same cycle.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctl_t;

  // True when a ranks above b: larger category, then larger date value,
  // then smaller arrival number. One wide unsigned compare covers all three.
  function automatic logic ranks_above(entry_t a, entry_t b);
    logic [3+DATE_W+ARR_W-1:0] ka;
    logic [3+DATE_W+ARR_W-1:0] kb;
    ka = {a.cat, a.date, ~a.arrival};
    kb = {b.cat, b.date, ~b.arrival};
    return ka > kb;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ckpq_cell.sv
// ----------------------------------------------------------------------------
// ckpq_cell
// One slot of the sorted chain: holds an entry and shifts it to a neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module ckpq_cell (
  input  wire logic                clk_i,
  input  wire ckpq_pkg::cell_ctl_t ctl_i,
  input  wire logic                occ_i,
  input  wire ckpq_pkg::entry_t    new_i,
  input  wire ckpq_pkg::entry_t    left_i,
  input  wire logic                left_here_i,
  input  wire ckpq_pkg::entry_t    right_i,
  output ckpq_pkg::entry_t         entry_o,
  output logic                     here_o
);

  ckpq_pkg::entry_t entry_q;
  ckpq_pkg::entry_t entry_d;

  // The new entry belongs at or before this slot when the slot is empty or
  // holds a lower ranked entry. Along the chain this flag is monotone.
  assign here_o = !occ_i || ckpq_pkg::ranks_above(new_i, entry_q);

  // Insert: slots from the insertion point move one place down, and the
  // first of them takes the new entry. Remove: every slot moves up one.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert && here_o) begin
      entry_d = left_here_i ? left_i : new_i;
    end else if (ctl_i.remove) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> hw/rtl/ckpq_chain.sv
// ----------------------------------------------------------------------------
// ckpq_chain
// Row of cells kept in descending rank order; slot zero holds the top entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ckpq_chain (
  input  wire logic                         clk_i,
  input  wire ckpq_pkg::cell_ctl_t          ctl_i,
  input  wire logic [ckpq_pkg::CNT_W-1:0]   count_i,
  input  wire ckpq_pkg::entry_t             new_i,
  output ckpq_pkg::entry_t                  head_o
);

  ckpq_pkg::entry_t ent   [ckpq_pkg::NUM_CELLS];
  logic             here  [ckpq_pkg::NUM_CELLS];

  // Each cell sees its left and right neighbours; the ends are tied off.
  for (genvar i = 0; i < ckpq_pkg::NUM_CELLS; i++) begin : g_cell
    ckpq_pkg::entry_t left_ent;
    ckpq_pkg::entry_t right_ent;
    logic             left_here;
    logic             occ;

    assign occ = ckpq_pkg::CNT_W'(i) < count_i;

    if (i == 0) begin : g_first
      assign left_ent  = new_i;
      assign left_here = 1'b0;
    end else begin : g_mid
      assign left_ent  = ent[i-1];
      assign left_here = here[i-1];
    end

    if (i == ckpq_pkg::NUM_CELLS - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    ckpq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .occ_i       (occ),
      .new_i       (new_i),
      .left_i      (left_ent),
      .left_here_i (left_here),
      .right_i     (right_ent),
      .entry_o     (ent[i]),
      .here_o      (here[i])
    );
  end

  assign head_o = ent[0];

endmodule

`default_nettype wire

>>> hw/rtl/composite_key_priority_queue.sv
// ----------------------------------------------------------------------------
// composite_key_priority_queue
// Bounded max-priority queue on a systolic sorted chain of cells.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------
//   in      | input     | in_valid_i / in_stall_o   | ckpq_pkg::in_t
//   out     | output    | out_valid_o / out_stall_i | ckpq_pkg::out_t
//
// Each request is handled in two steps: capture it and form the date value,
// then an execute step in which every cell of the chain compares and shifts in parallel.
// A new request is accepted only once the previous one has executed; a
// stalled result holds the chain operation until it is taken.
// Reset clears the state, fill count, arrival counter, pending-peek flag and
// result valid; the cell contents need no clearing, as only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module composite_key_priority_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ckpq_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ckpq_pkg::out_t      out_data_o
);

  ckpq_pkg::state_e                state_q, state_d;
  logic [ckpq_pkg::CNT_W-1:0]      count_q, count_d;
  logic [ckpq_pkg::ARR_W-1:0]      arr_q, arr_d;
  logic                            pend_q, pend_d;
  logic                            out_valid_q, out_valid_d;
  ckpq_pkg::out_t                  out_q, out_d;
  logic [1:0]                      req_q;
  ckpq_pkg::entry_t                new_q;
  ckpq_pkg::entry_t                head;
  ckpq_pkg::cell_ctl_t             ctl;
  logic                            in_acc;
  logic                            go;
  logic [ckpq_pkg::DATE_W-1:0]     in_date;

  assign in_stall_o = (state_q != ckpq_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Date value of the incoming entry.
  assign in_date = ckpq_pkg::DATE_W'(in_data_i.year) * ckpq_pkg::DATE_W'(ckpq_pkg::YEAR_MUL)
                 + ckpq_pkg::DATE_W'(in_data_i.month) * ckpq_pkg::DATE_W'(ckpq_pkg::MONTH_MUL)
                 + ckpq_pkg::DATE_W'(in_data_i.day);

  // Request capture register. The arrival counter only moves while a request
  // executes, so its value here is the one the insert will be given.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q         <= in_data_i.req_type;
      new_q.cat     <= in_data_i.category_code;
      new_q.year    <= in_data_i.year;
      new_q.month   <= in_data_i.month;
      new_q.day     <= in_data_i.day;
      new_q.date    <= in_date;
      new_q.arrival <= arr_q;
      new_q.tag     <= in_data_i.subject_tag;
    end
  end

  ckpq_chain u_chain (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .count_i (count_q),
    .new_i   (new_q),
    .head_o  (head)
  );

  // Sequencer: next state, chain control and result formation.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    arr_d       = arr_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ctl         = '0;
    go          = !out_valid_q || !out_stall_i;

    case (state_q)
      ckpq_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = ckpq_pkg::S_EXEC;
        end
      end
      ckpq_pkg::S_EXEC: begin
        if (go) begin
          state_d     = ckpq_pkg::S_IDLE;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = ckpq_pkg::STAT_DONE;
          case (ckpq_pkg::req_e'(req_q))
            ckpq_pkg::REQ_INSERT: begin
              if (count_q == ckpq_pkg::CNT_W'(ckpq_pkg::NUM_CELLS)) begin
                out_d.status = ckpq_pkg::STAT_FULL;
              end else begin
                ctl.insert = 1'b1;
                count_d    = count_q + 1'b1;
                arr_d      = arr_q + 1'b1;
              end
            end
            ckpq_pkg::REQ_PEEK: begin
              if (count_q == '0 || pend_q) begin
                out_d.status = ckpq_pkg::STAT_INVALID;
              end else begin
                pend_d             = 1'b1;
                out_d.top_category = head.cat;
                out_d.top_year     = head.year;
                out_d.top_month    = head.month;
                out_d.top_day      = head.day;
                out_d.top_tag      = head.tag;
              end
            end
            ckpq_pkg::REQ_REMOVE: begin
              if (count_q == '0 || !pend_q) begin
                out_d.status = ckpq_pkg::STAT_INVALID;
              end else begin
                ctl.remove = 1'b1;
                count_d    = count_q - 1'b1;
                pend_d     = 1'b0;
              end
            end
            default: begin
              // Count request: status done, nothing changes.
            end
          endcase
          out_d.entry_count = 7'(count_d);
        end
      end
      default: begin
        state_d = ckpq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ckpq_pkg::S_IDLE;
      count_q     <= '0;
      arr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      arr_q       <= arr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/ckpq_checker.sv
// ----------------------------------------------------------------------------
// ckpq_checker
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ckpq_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_stall_o,
  input wire ckpq_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire ckpq_pkg::out_t out_data_o
);

  // One request is worked on at a time: the input stalls after a transaction.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a request is in flight");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A refused insert only happens with the store full.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ckpq_pkg::STAT_FULL |->
      out_data_o.entry_count == 7'(ckpq_pkg::NUM_CELLS))
    else $error("full status with store not full");

  // A refused request (status not done) carries no top category, year or tag.
  a_no_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ckpq_pkg::STAT_DONE |->
      out_data_o.top_category == '0 && out_data_o.top_year == '0 &&
      out_data_o.top_tag == '0)
    else $error("top entry reported on a refused request");

endmodule

bind composite_key_priority_queue ckpq_checker u_ckpq_checker (.*);

`default_nettype wire
